// File: hdl/osmt_pkg.sv
`timescale 1ns / 1ps

package osmt_pkg;

   // table geometry
   localparam int CAPACITY   = 16;
   localparam int ITEM_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // stream field widths
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // command codes
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic exec_op;
      logic dump_start;
      logic dump_step;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
      logic count_zero;
      logic idx_last;
   } dp_status_type;

endpackage

// File: hdl/ordered_set_membership_table.sv
`timescale 1ns / 1ps

// Insertion-ordered set of up to CAPACITY signed values.
// Input channel req_: one item carries a command in req_tuser (add, remove,
// query, dump) and a value in req_tdata. Result channel rsp_: every result
// carries membership before the operation, the count after it, a refused-add
// flag, and during dump one stored entry; rsp_tlast marks the final result.
// Add, remove and query: all entries are compared in parallel, the table is
// updated and the result is registered at the accepting edge, so it appears
// in the next cycle; one item per cycle while the receiver keeps rsp_tready high.
// Dump: the item is taken, then, while the output register is free, one entry
// per cycle is loaded into it from the dump index (one result marked last when
// the table is empty); no new item is taken until the last entry is loaded.
// A stalled receiver holds the output register; req_tready stays low until the
// pending result is taken or is being taken in the same cycle.
// Reset (synchronous, active high) empties the table and drops any pending
// result; stored entries are not cleared and are never read until rewritten.
module ordered_set_membership_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] item_value
   input  logic [osmt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] cmd
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [4:0] set_count, [36:5] element, [39:37] zero
   output logic [osmt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] was_member, [1] table_full, [2] element_valid
   output logic [osmt_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   osmt_pkg::ctl_cmd_type          cmd;
   osmt_pkg::dp_status_type        status;
   osmt_pkg::op_type               op;
   logic                           was_member;
   logic [osmt_pkg::COUNT_W-1:0]   set_count;
   logic                           table_full;
   logic [osmt_pkg::VALUE_W-1:0]   element;
   logic                           element_valid;

   assign op = osmt_pkg::op_type'(req_tuser);

   osmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (op),
      .status     (status),
      .cmd        (cmd)
   );

   osmt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .op                (op),
      .value             (req_tdata[osmt_pkg::VALUE_W-1:0]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_was_member    (was_member),
      .rsp_set_count     (set_count),
      .rsp_table_full    (table_full),
      .rsp_element       (element),
      .rsp_element_valid (element_valid),
      .rsp_last          (rsp_tlast)
   );

   // pack result fields
   assign rsp_tdata = {3'b000, element, set_count};
   assign rsp_tuser = {element_valid, table_full, was_member};

endmodule

// File: hdl/osmt_ctrl.sv
`timescale 1ns / 1ps

module osmt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  osmt_pkg::op_type         op,
   input  osmt_pkg::dp_status_type  status,
   output osmt_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_RUN  = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // accept only while running and the output slot can take a result
   assign req_tready = (state_ff == ST_RUN) && status.rsp_free;
   assign accept     = req_tvalid && req_tready;

   // next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd.exec_op    = 1'b0;
      cmd.dump_start = 1'b0;
      cmd.dump_step  = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if ((op == osmt_pkg::OP_DUMP) && !status.count_zero) begin
                  cmd.dump_start = 1'b1;
                  state_in       = ST_DUMP;
               end else begin
                  cmd.exec_op = 1'b1;
               end
            end
         end
         ST_DUMP: begin
            if (status.rsp_free) begin
               cmd.dump_step = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec_op && cmd.dump_step))
      else $error("operation and dump step issued together");

   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> !req_tready)
      else $error("input ready during dump");

   a_dump_entered: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_start |=> (state_ff == ST_DUMP))
      else $error("dump start did not enter dump state");

endmodule

// File: hdl/osmt_datapath.sv
`timescale 1ns / 1ps

module osmt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  osmt_pkg::ctl_cmd_type               cmd,
   output osmt_pkg::dp_status_type             status,
   input  osmt_pkg::op_type                    op,
   input  logic [osmt_pkg::VALUE_W-1:0]        value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_was_member,
   output logic [osmt_pkg::COUNT_W-1:0]        rsp_set_count,
   output logic                                rsp_table_full,
   output logic [osmt_pkg::VALUE_W-1:0]        rsp_element,
   output logic                                rsp_element_valid,
   output logic                                rsp_last
);

   localparam int CAP = osmt_pkg::CAPACITY;
   localparam int IW  = osmt_pkg::ITEM_WIDTH;
   localparam int CW  = osmt_pkg::CNT_W;
   localparam int XW  = osmt_pkg::IDX_W;

   logic [IW-1:0] entry_ff [CAP];
   logic [IW-1:0] entry_in [CAP];
   logic [CW-1:0] count_ff, count_in;
   logic [XW-1:0] idx_ff, idx_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           was_member_ff, was_member_in;
   logic [osmt_pkg::COUNT_W-1:0]   set_count_ff, set_count_in;
   logic                           table_full_ff, table_full_in;
   logic [osmt_pkg::VALUE_W-1:0]   element_ff, element_in;
   logic                           element_valid_ff, element_valid_in;
   logic                           last_ff, last_in;

   logic [63:0]    value_ext;
   logic [IW-1:0]  key;
   logic [CAP-1:0] hit_vec;
   logic [CAP-1:0] shift_vec;
   logic           hit;
   logic           is_full;
   logic [63:0]    count_ext;
   logic [63:0]    elem_ext;
   logic [CW-1:0]  count_less;
   logic [CW-1:0]  idx_wide;

   // sign extend the value, then keep the stored width
   assign value_ext = {{(64 - osmt_pkg::VALUE_W){value[osmt_pkg::VALUE_W-1]}}, value};
   assign key       = value_ext[IW-1:0];

   // parallel compare against the live entries
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         hit_vec[i] = (CW'(i) < count_ff) && (entry_ff[i] == key);
      end
   end
   assign hit     = |hit_vec;
   assign is_full = (count_ff == CW'(CAP));

   // entries at and above the match move down one place on remove
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         shift_vec[i] = |(hit_vec & ({CAP{1'b1}} >> (CAP - 1 - i)));
      end
   end

   assign count_less = count_ff - CW'(1);
   assign idx_wide   = CW'(idx_ff);

   // status back to the controller
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.count_zero = (count_ff == '0);
   assign status.idx_last   = (idx_wide == count_less);

   // table update
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         entry_in[i] = entry_ff[i];
      end
      count_in = count_ff;
      if (cmd.exec_op) begin
         case (op)
            osmt_pkg::OP_ADD: begin
               if (!hit && !is_full) begin
                  entry_in[count_ff[XW-1:0]] = key;
                  count_in = count_ff + CW'(1);
               end
            end
            osmt_pkg::OP_REMOVE: begin
               if (hit) begin
                  for (int i = 0; i < CAP - 1; i++) begin
                     if (shift_vec[i]) begin
                        entry_in[i] = entry_ff[i + 1];
                     end
                  end
                  count_in = count_less;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // dump index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.dump_start) begin
         idx_in = '0;
      end else if (cmd.dump_step) begin
         idx_in = idx_ff + XW'(1);
      end
   end

   assign count_ext = 64'(count_in);
   assign elem_ext  = 64'(entry_ff[idx_ff]);

   // output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      was_member_in    = was_member_ff;
      set_count_in     = set_count_ff;
      table_full_in    = table_full_ff;
      element_in       = element_ff;
      element_valid_in = element_valid_ff;
      last_in          = last_ff;
      if (cmd.exec_op) begin
         rsp_valid_in     = 1'b1;
         was_member_in    = hit && (op != osmt_pkg::OP_DUMP);
         set_count_in     = count_ext[osmt_pkg::COUNT_W-1:0];
         table_full_in    = (op == osmt_pkg::OP_ADD) && !hit && is_full;
         element_in       = '0;
         element_valid_in = 1'b0;
         last_in          = 1'b1;
      end else if (cmd.dump_step) begin
         rsp_valid_in     = 1'b1;
         was_member_in    = 1'b0;
         set_count_in     = count_ext[osmt_pkg::COUNT_W-1:0];
         table_full_in    = 1'b0;
         element_in       = elem_ext[osmt_pkg::VALUE_W-1:0];
         element_valid_in = 1'b1;
         last_in          = status.idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAP; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      idx_ff           <= idx_in;
      was_member_ff    <= was_member_in;
      set_count_ff     <= set_count_in;
      table_full_ff    <= table_full_in;
      element_ff       <= element_in;
      element_valid_ff <= element_valid_in;
      last_ff          <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_member    = was_member_ff;
   assign rsp_set_count     = set_count_ff;
   assign rsp_table_full    = table_full_ff;
   assign rsp_element       = element_ff;
   assign rsp_element_valid = element_valid_ff;
   assign rsp_last          = last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAP))
      else $error("entry count above capacity");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec_op || cmd.dump_step) |=> rsp_valid_ff)
      else $error("result load lost");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec_op || cmd.dump_step) |-> status.rsp_free)
      else $error("result loaded over a pending item");

endmodule
